### src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none
package lpht_pkg;
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int KEY_BYTES   = 8;
   localparam int KEY_W       = 8 * KEY_BYTES;
   localparam int LEN_W       = 4;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 9;
   localparam logic [31:0] HASH_INIT = 32'd5381;
   localparam int HASH_SHIFT  = 5;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_DUP       = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // one classified transaction waiting for the probe engine
   typedef struct packed {
      logic [1:0]         mode;
      logic [KEY_W-1:0]   key;
      logic [LEN_W-1:0]   len;
      logic [VALUE_W-1:0] value;
      logic               overwrite;
      logic [IDX_W-1:0]   home;
   } op_type;
endpackage
`default_nettype wire

### src/lpht_front.sv
// ----------------------------------------------------------------------------
// lpht_front
// Accepts a transaction, clamps and masks the key, hashes one byte a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [1:0]                       req_mode,
   input  wire  [lpht_pkg::KEY_W-1:0]       req_key_bytes,
   input  wire  [lpht_pkg::LEN_W-1:0]       req_key_length,
   input  wire  [lpht_pkg::VALUE_W-1:0]     req_value_in,
   input  wire                              req_allow_overwrite,
   output logic                             push,
   output lpht_pkg::op_type                 push_op,
   input  wire                              q_full
);
   typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_type;

   fstate_type                 state_ff, state_in;
   lpht_pkg::op_type           op_ff, op_in;
   logic [31:0]                hash_ff, hash_in;
   logic [lpht_pkg::LEN_W-1:0] cnt_ff, cnt_in;
   logic [lpht_pkg::LEN_W-1:0] len_c;
   logic [lpht_pkg::KEY_W-1:0] key_c;
   logic [7:0]                 byte_c;

   always_comb begin
      len_c = (req_key_length > lpht_pkg::LEN_W'(lpht_pkg::KEY_BYTES)) ?
              lpht_pkg::LEN_W'(lpht_pkg::KEY_BYTES) : req_key_length;
      for (int i = 0; i < lpht_pkg::KEY_BYTES; i++) begin
         key_c[8*i +: 8] = (lpht_pkg::LEN_W'(i) < len_c) ? req_key_bytes[8*i +: 8] : 8'd0;
      end
      byte_c = op_ff.key[{cnt_ff[2:0], 3'b000} +: 8];
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      hash_in  = hash_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               op_in.mode      = req_mode;
               op_in.key       = key_c;
               op_in.len       = len_c;
               op_in.value     = req_value_in;
               op_in.overwrite = req_allow_overwrite;
               hash_in         = lpht_pkg::HASH_INIT;
               cnt_in          = '0;
               state_in        = F_HASH;
            end
         end
         F_HASH: begin
            if (cnt_ff == op_ff.len) begin
               op_in.home = hash_ff[lpht_pkg::IDX_W-1:0];
               state_in   = F_PUSH;
            end else begin
               hash_in = (hash_ff << lpht_pkg::HASH_SHIFT) + hash_ff + {24'd0, byte_c};
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      hash_ff <= hash_in;
      cnt_ff  <= cnt_in;
   end

   assign busy    = (state_ff != F_IDLE);
   assign push_op = op_ff;
endmodule
`default_nettype wire

### src/lpht_queue.sv
// ----------------------------------------------------------------------------
// lpht_queue
// Two-entry queue between the hashing front and the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  lpht_pkg::op_type  push_op,
   output logic              full,
   input  wire               pop,
   output logic              not_empty,
   output lpht_pkg::op_type  head_op
);
   lpht_pkg::op_type entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) entry_ff[wr_ptr_ff] <= push_op;
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_op   = entry_ff[rd_ptr_ff];

   a_no_overflow:  assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("queue underflow");
   a_count_range:  assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
endmodule
`default_nettype wire

### src/lpht_back.sv
// ----------------------------------------------------------------------------
// lpht_back
// Probe engine: walks the table one slot at a time, read then check, and answers.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_back (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  [7:0]                         load_limit,
   input  wire                                q_not_empty,
   input  lpht_pkg::op_type                   head_op,
   output logic                               pop,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [lpht_pkg::VALUE_W-1:0]       rsp_value_out,
   output logic [7:0]                         rsp_entry_count_out
);
   typedef enum logic [1:0] {B_IDLE, B_READ, B_CHECK} bstate_type;

   localparam logic [lpht_pkg::IDX_W-1:0] LAST_STEP = lpht_pkg::IDX_W'(lpht_pkg::TABLE_DEPTH - 1);

   bstate_type                      state_ff, state_in;
   lpht_pkg::op_type                op_ff, op_in;
   logic [lpht_pkg::IDX_W-1:0]      idx_ff, idx_in, step_ff, step_in;
   logic                            found_ff, found_in;
   logic [lpht_pkg::VALUE_W-1:0]    vout_ff, vout_in;
   logic [lpht_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [lpht_pkg::TABLE_DEPTH-1:0] occ_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      status_ff, status_in;
   logic [lpht_pkg::VALUE_W-1:0]    rvalue_ff, rvalue_in;
   logic [7:0]                      rcount_ff, rcount_in;

   // slot storage, read data registered
   logic [lpht_pkg::KEY_W-1:0]   key_mem [lpht_pkg::TABLE_DEPTH];
   logic [lpht_pkg::LEN_W-1:0]   len_mem [lpht_pkg::TABLE_DEPTH];
   logic [lpht_pkg::VALUE_W-1:0] val_mem [lpht_pkg::TABLE_DEPTH];
   logic [lpht_pkg::KEY_W-1:0]   key_rd_ff;
   logic [lpht_pkg::LEN_W-1:0]   len_rd_ff;
   logic [lpht_pkg::VALUE_W-1:0] val_rd_ff;

   logic key_wr, val_wr, occ_set, occ_clr, occ_c, match_c, done_c;
   logic [1:0] done_status;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      vout_in      = vout_ff;
      count_in     = count_ff;
      pop          = 1'b0;
      key_wr       = 1'b0;
      val_wr       = 1'b0;
      occ_set      = 1'b0;
      occ_clr      = 1'b0;
      done_c       = 1'b0;
      done_status  = lpht_pkg::ST_NOT_FOUND;
      occ_c        = occ_ff[idx_ff];
      match_c      = occ_c && (len_rd_ff == op_ff.len) && (key_rd_ff == op_ff.key);
      case (state_ff)
         B_IDLE: begin
            if (q_not_empty) begin
               pop      = 1'b1;
               op_in    = head_op;
               idx_in   = head_op.home;
               step_in  = '0;
               found_in = 1'b0;
               vout_in  = '0;
               if (head_op.mode == lpht_pkg::MODE_INSERT &&
                   count_ff >= {1'b0, load_limit}) begin
                  done_c      = 1'b1;
                  done_status = lpht_pkg::ST_FULL;
               end else if (head_op.mode != lpht_pkg::MODE_INSERT &&
                            head_op.mode != lpht_pkg::MODE_LOOKUP &&
                            head_op.mode != lpht_pkg::MODE_DELETE) begin
                  done_c = 1'b1;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_READ: state_in = B_CHECK;
         B_CHECK: begin
            state_in = B_READ;
            if (!occ_c) begin
               done_c = 1'b1;
               if (op_ff.mode == lpht_pkg::MODE_INSERT) begin
                  done_status = lpht_pkg::ST_OK;
                  if (!found_ff) begin
                     key_wr   = 1'b1;
                     val_wr   = 1'b1;
                     occ_set  = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  done_status = found_ff ? lpht_pkg::ST_OK : lpht_pkg::ST_NOT_FOUND;
               end
            end else begin
               if (match_c) begin
                  found_in = 1'b1;
                  if (op_ff.mode == lpht_pkg::MODE_INSERT) begin
                     val_wr = op_ff.overwrite;
                  end else if (op_ff.mode == lpht_pkg::MODE_LOOKUP) begin
                     vout_in = val_rd_ff;
                  end else begin
                     occ_clr = 1'b1;
                     if (count_ff != '0) count_in = count_ff - 1'b1;
                  end
               end
               if (match_c && op_ff.mode == lpht_pkg::MODE_INSERT && !op_ff.overwrite) begin
                  done_c      = 1'b1;
                  done_status = lpht_pkg::ST_DUP;
               end else if (step_ff == LAST_STEP) begin
                  done_c = 1'b1;
                  if (op_ff.mode == lpht_pkg::MODE_INSERT) begin
                     done_status = found_in ? lpht_pkg::ST_OK : lpht_pkg::ST_FULL;
                  end else begin
                     done_status = found_in ? lpht_pkg::ST_OK : lpht_pkg::ST_NOT_FOUND;
                  end
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  step_in = step_ff + 1'b1;
               end
            end
            if (done_c) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
      rsp_valid_in = done_c;
      status_in    = done_status;
      rvalue_in    = (state_ff == B_CHECK && op_ff.mode == lpht_pkg::MODE_LOOKUP &&
                      done_status == lpht_pkg::ST_OK) ? vout_in : '0;
      rcount_in    = (count_in > lpht_pkg::COUNT_W'(255)) ? 8'hFF : count_in[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (occ_set) occ_ff[idx_ff] <= 1'b1;
         if (occ_clr) occ_ff[idx_ff] <= 1'b0;
      end
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      step_ff   <= step_in;
      found_ff  <= found_in;
      vout_ff   <= vout_in;
      status_ff <= status_in;
      rvalue_ff <= rvalue_in;
      rcount_ff <= rcount_in;
   end

   always_ff @(posedge clock) begin
      if (key_wr) begin
         key_mem[idx_ff] <= op_ff.key;
         len_mem[idx_ff] <= op_ff.len;
      end
      if (val_wr) val_mem[idx_ff] <= op_ff.value;
      key_rd_ff <= key_mem[idx_ff];
      len_rd_ff <= len_mem[idx_ff];
      val_rd_ff <= val_mem[idx_ff];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_value_out       = rvalue_ff;
   assign rsp_entry_count_out = rcount_ff;

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_CHECK |-> $past(state_ff) == B_READ)
      else $error("slot checked without a read");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !count_ff[lpht_pkg::COUNT_W-1])
      else $error("entry count overflow");
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != lpht_pkg::ST_OK |-> rvalue_ff == '0)
      else $error("value on failed transaction");
endmodule
`default_nettype wire

### src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key-value table, djb2 hash, open addressing with linear probing.
// ----------------------------------------------------------------------------
// Usage:
//  - A transaction (insert, lookup or delete) is taken at a clock edge with
//    start high and busy low. busy is high while the front hashes the key
//    and until the transaction has been handed to the queue.
//  - The front hashes the key one byte per cycle over the clamped key_length
//    and, once the queue has room, hands the transaction to a two-entry queue,
//    so it can take the next command while the probe engine is still walking.
//  - The probe engine takes the queue head in its idle state and visits each
//    slot in a read state (registered slot memory read), then a check state
//    (compare/update); a walk ends at an empty slot, a duplicate, or after all
//    slots. The engine takes no new transaction until its walk has ended.
//  - Inserts refused at the load limit and unused modes are answered from the
//    engine's idle state without a walk.
//  - Each result shows on rsp_* for one cycle with rsp_valid; there is no
//    back pressure on the result side.
//  - Reset clears the occupancy bits, the entry count and sets load_limit to
//    128; no clearing pass is needed. Write load_limit through csr_* only
//    while no transaction is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_probe_hash_table (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  wire  [1:0]                      req_mode,
   input  wire  [63:0]                     req_key_bytes,
   input  wire  [3:0]                      req_key_length,
   input  wire  [31:0]                     req_value_in,
   input  wire                             req_allow_overwrite,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [31:0]                     rsp_value_out,
   output logic [7:0]                      rsp_entry_count_out,
   input  wire                             csr_write_enable,
   input  wire  [7:0]                      csr_write_data
);
   logic [7:0]       load_limit_ff;
   logic             push, q_full, q_not_empty, pop;
   lpht_pkg::op_type push_op, head_op;

   // load limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= 8'd128;
      end else if (csr_write_enable) begin
         load_limit_ff <= csr_write_data;
      end
   end

   lpht_front u_front (
      .clock, .reset, .start, .busy,
      .req_mode, .req_key_bytes, .req_key_length, .req_value_in, .req_allow_overwrite,
      .push, .push_op, .q_full
   );

   lpht_queue u_queue (
      .clock, .reset, .push, .push_op,
      .full(q_full), .pop, .not_empty(q_not_empty), .head_op
   );

   lpht_back u_back (
      .clock, .reset, .load_limit(load_limit_ff),
      .q_not_empty, .head_op, .pop,
      .rsp_valid, .rsp_status, .rsp_value_out, .rsp_entry_count_out
   );
endmodule
`default_nettype wire
